// ----- rtl/wsfv_pkg.sv -----
// Shared types, codes and helper functions for the WebSocket frame validator.
// No dependencies; used by websocket_frame_validator_top.
`default_nettype none

package wsfv_pkg;

  // Field widths
  localparam int unsigned LenW     = 63;
  localparam int unsigned InDataW  = 88;   // 81 bits of fields, padded to bytes
  localparam int unsigned OutDataW = 8;    // 7 bits of fields, padded to a byte

  // Opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Input kind carried in tuser
  localparam logic FUNC_HEADER  = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  // Frame kinds
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_TEXT  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  // Violation codes
  localparam logic [3:0] V_NONE       = 4'd0;
  localparam logic [3:0] V_OPCODE     = 4'd1;
  localparam logic [3:0] V_RSV        = 4'd2;
  localparam logic [3:0] V_CTRL_FRAG  = 4'd3;
  localparam logic [3:0] V_CTRL_LONG  = 4'd4;
  localparam logic [3:0] V_UNMASKED   = 4'd5;
  localparam logic [3:0] V_MASKED     = 4'd6;
  localparam logic [3:0] V_ORPHAN     = 4'd7;
  localparam logic [3:0] V_NEW_IN_FRG = 4'd8;
  localparam logic [3:0] V_TEXT_UTF8  = 4'd9;
  localparam logic [3:0] V_CLOSE_ONE  = 4'd10;
  localparam logic [3:0] V_CLOSE_CODE = 4'd11;
  localparam logic [3:0] V_REASON_UTF = 4'd12;

  // Close status codes
  localparam logic [1:0] CS_NONE     = 2'd0;
  localparam logic [1:0] CS_PROTOCOL = 2'd1;
  localparam logic [1:0] CS_PAYLOAD  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_IS_SERVER = 1'b0;
  localparam logic CFG_EXT_NEG   = 1'b1;

  localparam logic [6:0] CTRL_MAX_LEN = 7'd125;

  // Unpacked input item
  typedef struct packed {
    logic            func;
    logic            fin;
    logic [2:0]      rsv_bits;
    logic [3:0]      opcode;
    logic            masked;
    logic [LenW-1:0] payload_length;
    logic            has_payload;
    logic [7:0]      data_byte;
    logic            last_byte;
  } item_t;

  // Loose UTF-8 checker state
  typedef struct packed {
    logic [1:0] pending;
    logic       fault;
  } utf8_t;

  // One byte through the UTF-8 checker
  function automatic utf8_t utf8_feed(utf8_t s, logic [7:0] b);
    utf8_t r;
    r = s;
    if (s.pending != 2'd0) begin
      if ((b & 8'hC0) != 8'h80) r.fault = 1'b1;
      else r.pending = s.pending - 2'd1;
    end else if (b[7]) begin
      if ((b & 8'hE0) == 8'hC0) r.pending = 2'd1;
      else if ((b & 8'hF0) == 8'hE0) r.pending = 2'd2;
      else if ((b & 8'hF8) == 8'hF0) r.pending = 2'd3;
      else r.fault = 1'b1;
    end
    return r;
  endfunction

  // Close codes that are not allowed on the wire
  function automatic logic close_code_bad(logic [15:0] c);
    return (c < 16'd1000) || (c >= 16'd1004 && c <= 16'd1006) ||
           (c >= 16'd1012 && c <= 16'd2999);
  endfunction

  // Close status for a violation
  function automatic logic [1:0] status_of(logic [3:0] v);
    logic [1:0] s;
    s = CS_NONE;
    if (v == V_TEXT_UTF8 || v == V_REASON_UTF) s = CS_PAYLOAD;
    else if (v != V_NONE) s = CS_PROTOCOL;
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/websocket_frame_validator_top.sv -----
// WebSocket frame validator top level: header checks, fragmentation tracking,
// UTF-8 and close-payload checks, one verdict per frame. Uses wsfv_pkg.
`default_nettype none

// Channel  | Direction | Handshake          | Contents
// s_       | in        | s_tvalid/s_tready  | header or payload byte item
// m_       | out       | m_tvalid/m_tready  | one verdict per finished frame
// cfg_     | in        | cfg_valid/cfg_ready| register index and value
//
// One item per cycle while the output is not stalled; an item is held in the input register
// and its verdict is then loaded into the output register.
// The output register decouples the sides: input stalls only while a verdict
// waits and m_tready is low. Configuration is always ready.
// rst (synchronous, high) clears valids, fragmentation and frame state, and
// loads is_server = 1, extensions_negotiated = 0.

module websocket_frame_validator_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // stream in
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // tdata: fin, rsv_bits[2:0], opcode[3:0], masked, payload_length[62:0],
  //        has_payload, data_byte[7:0], zero pad
  input  wire logic [wsfv_pkg::InDataW-1:0] s_tdata,
  input  wire logic                         s_tuser,  // func
  input  wire logic                         s_tlast,  // last_byte
  // stream out
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // tdata: frame_ok, violation[3:0], close_status[1:0], zero pad
  output logic [wsfv_pkg::OutDataW-1:0]     m_tdata,
  // configuration
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_index,
  input  wire logic                         cfg_data
);

  // Configuration registers
  logic is_server;
  logic extensions_negotiated;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_server             <= 1'b1;
      extensions_negotiated <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wsfv_pkg::CFG_IS_SERVER: is_server             <= cfg_data;
        wsfv_pkg::CFG_EXT_NEG:   extensions_negotiated <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic            in_valid;
  wsfv_pkg::item_t item;
  logic            adv;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.func           <= s_tuser;
      item.fin            <= s_tdata[0];
      item.rsv_bits       <= s_tdata[3:1];
      item.opcode         <= s_tdata[7:4];
      item.masked         <= s_tdata[8];
      item.payload_length <= s_tdata[71:9];
      item.has_payload    <= s_tdata[72];
      item.data_byte      <= s_tdata[80:73];
      item.last_byte      <= s_tlast;
    end
  end

  // Frame state
  logic              in_fragment, in_fragment_next;
  logic              frame_active, frame_active_next;
  logic [1:0]        frame_kind, frame_kind_next;
  logic [3:0]        header_fault, header_fault_next;
  logic [1:0]        byte_count, byte_count_next;
  logic [15:0]       close_code_value, close_code_value_next;
  wsfv_pkg::utf8_t   utf8, utf8_next;

  logic       produce;
  logic [3:0] verdict;
  logic       step;

  assign step = in_valid && adv;

  // Header checks, in priority order
  logic       is_ctrl;
  logic       op_bad;
  logic       len_long;
  logic [3:0] hdr_v;
  logic       frag_after;

  always_comb begin
    is_ctrl    = item.opcode[3];
    op_bad     = (item.opcode > wsfv_pkg::OP_PONG) ||
                 (item.opcode > wsfv_pkg::OP_BIN && !item.opcode[3]);
    len_long   = (|item.payload_length[wsfv_pkg::LenW-1:7]) ||
                 (item.payload_length[6:0] > wsfv_pkg::CTRL_MAX_LEN);
    hdr_v      = wsfv_pkg::V_NONE;
    frag_after = in_fragment;
    if (op_bad) hdr_v = wsfv_pkg::V_OPCODE;
    else if (!extensions_negotiated && item.rsv_bits != 3'd0) hdr_v = wsfv_pkg::V_RSV;
    else if (is_ctrl && !item.fin) hdr_v = wsfv_pkg::V_CTRL_FRAG;
    else if (is_ctrl && len_long) hdr_v = wsfv_pkg::V_CTRL_LONG;
    else if (is_server && !item.masked) hdr_v = wsfv_pkg::V_UNMASKED;
    else if (!is_server && item.masked) hdr_v = wsfv_pkg::V_MASKED;
    else if (item.opcode == wsfv_pkg::OP_CONT) begin
      if (!in_fragment) hdr_v = wsfv_pkg::V_ORPHAN;
      else if (item.fin) frag_after = 1'b0;
    end else if (item.opcode == wsfv_pkg::OP_TEXT || item.opcode == wsfv_pkg::OP_BIN) begin
      if (in_fragment) hdr_v = wsfv_pkg::V_NEW_IN_FRG;
      else if (!item.fin) frag_after = 1'b1;
    end
    if (hdr_v != wsfv_pkg::V_NONE) frag_after = 1'b0;
  end

  // Per-item state update and verdict
  wsfv_pkg::utf8_t fed;
  logic [15:0]     code_shift;

  always_comb begin
    in_fragment_next      = in_fragment;
    frame_active_next     = frame_active;
    frame_kind_next       = frame_kind;
    header_fault_next     = header_fault;
    byte_count_next       = byte_count;
    close_code_value_next = close_code_value;
    utf8_next             = utf8;
    produce               = 1'b0;
    verdict               = wsfv_pkg::V_NONE;
    fed                   = wsfv_pkg::utf8_feed(utf8, item.data_byte);
    code_shift            = {close_code_value[7:0], item.data_byte};

    if (item.func == wsfv_pkg::FUNC_HEADER) begin
      // New header restarts frame state
      in_fragment_next      = frag_after;
      frame_kind_next       = (item.opcode == wsfv_pkg::OP_TEXT)  ? wsfv_pkg::KIND_TEXT  :
                              (item.opcode == wsfv_pkg::OP_CLOSE) ? wsfv_pkg::KIND_CLOSE :
                                                                    wsfv_pkg::KIND_OTHER;
      header_fault_next     = hdr_v;
      byte_count_next       = 2'd0;
      close_code_value_next = 16'd0;
      utf8_next             = '0;
      frame_active_next     = item.has_payload;
      produce               = !item.has_payload;
      verdict               = hdr_v;
    end else if (frame_active) begin
      // Payload byte of an open frame
      if (header_fault == wsfv_pkg::V_NONE) begin
        if (frame_kind == wsfv_pkg::KIND_TEXT) begin
          utf8_next = fed;
        end else if (frame_kind == wsfv_pkg::KIND_CLOSE) begin
          if (byte_count < 2'd2) close_code_value_next = code_shift;
          else utf8_next = fed;
        end
      end
      if (byte_count != 2'd3) byte_count_next = byte_count + 2'd1;

      if (item.last_byte) begin
        frame_active_next = 1'b0;
        produce           = 1'b1;
        verdict           = header_fault;
        if (header_fault == wsfv_pkg::V_NONE) begin
          if (frame_kind == wsfv_pkg::KIND_TEXT) begin
            if (utf8_next.fault || utf8_next.pending != 2'd0)
              verdict = wsfv_pkg::V_TEXT_UTF8;
          end else if (frame_kind == wsfv_pkg::KIND_CLOSE) begin
            if (byte_count_next == 2'd1)
              verdict = wsfv_pkg::V_CLOSE_ONE;
            else if (wsfv_pkg::close_code_bad(close_code_value_next))
              verdict = wsfv_pkg::V_CLOSE_CODE;
            else if (utf8_next.fault || utf8_next.pending != 2'd0)
              verdict = wsfv_pkg::V_REASON_UTF;
          end
        end
        if (verdict != wsfv_pkg::V_NONE) in_fragment_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_fragment      <= 1'b0;
      frame_active     <= 1'b0;
      frame_kind       <= wsfv_pkg::KIND_OTHER;
      header_fault     <= wsfv_pkg::V_NONE;
      byte_count       <= 2'd0;
      close_code_value <= 16'd0;
      utf8             <= '0;
    end else if (step) begin
      in_fragment      <= in_fragment_next;
      frame_active     <= frame_active_next;
      frame_kind       <= frame_kind_next;
      header_fault     <= header_fault_next;
      byte_count       <= byte_count_next;
      close_code_value <= close_code_value_next;
      utf8             <= utf8_next;
    end
  end

  // Output register
  logic out_load;
  assign out_load = step && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, wsfv_pkg::status_of(verdict), verdict,
                  (verdict == wsfv_pkg::V_NONE)};
    end
  end

`ifndef ASSERT_OFF
  // Verdict flag agrees with the violation code
  a_ok_matches_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[4:1] == wsfv_pkg::V_NONE)))
    else $error("frame_ok disagrees with violation");

  // Invalid payload status only for the two UTF-8 violations
  a_status_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[6:5] == wsfv_pkg::CS_PAYLOAD) ==
                  (m_tdata[4:1] == wsfv_pkg::V_TEXT_UTF8 ||
                   m_tdata[4:1] == wsfv_pkg::V_REASON_UTF)))
    else $error("close_status disagrees with violation");

  // A failing verdict clears the fragmentation state
  a_fault_clears_frag: assert property (@(posedge clk) disable iff (rst)
    (out_load && verdict != wsfv_pkg::V_NONE) |=> !in_fragment)
    else $error("fragment state survived a violation");

  // A verdict is never produced while the output slot is full and stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !out_load)
    else $error("verdict overwrote a pending result");
`endif

endmodule

`default_nettype wire
